// File: design/tdf_pkg.sv
package tdf_pkg;

    localparam int VALUE_WIDTH  = 32;
    localparam int FACTOR_WIDTH = 32;
    localparam int MAX_RESULTS  = 32;
    localparam int CNT_WIDTH    = $clog2(MAX_RESULTS + 1);
    localparam int STEP_WIDTH   = $clog2(VALUE_WIDTH);

    typedef struct packed {
        logic load;       // capture input value, reset divisor to two
        logic start;      // begin one division rem / div
        logic take_quot;  // rem <= quotient
        logic inc_div;    // div <= div + 1
        logic emit;       // load output register
        logic emit_rem;   // output the remainder rather than the divisor
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic rem_lt2;
        logic div_gt_quot;
        logic rem_zero;
        logic quot_one;
    } dp_sts_t;

endpackage

// File: design/trial_division_factorizer.sv
// Trial-division prime factorizer.
// Input channel s_valid/s_ready/s_value carries one 32-bit number per
// transaction. The result channel m_valid/m_ready/m_factor/m_last returns the
// prime factors of that number in ascending order with repetition, one per
// transaction; m_last marks the final factor. Inputs 0 and 1 give nothing.
// s_ready is high only while no run is in progress.
// Each trial divisor passes through a start state, the bit-serial
// restoring divider and a decide state. The run length grows with the
// number of trials, which is about the larger of the second-largest prime
// factor and the square root of the largest, plus one per factor emitted; a
// 32-bit prime takes up to about 65536 trials.
// The final result waits in the output register while the next number is
// accepted. When the receiver stalls, the run holds before loading the next
// factor until the output register frees.
// Reset (aresetn low, synchronous) drops any run and clears m_valid.
module trial_division_factorizer (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [31:0]                      s_value,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [tdf_pkg::FACTOR_WIDTH-1:0] m_factor,
    output logic                             m_last
);
    import tdf_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    tdf_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_last  (m_last),
        .cmd     (cmd),
        .sts     (sts)
    );

    tdf_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_value  (s_value),
        .cmd      (cmd),
        .sts      (sts),
        .m_factor (m_factor)
    );

endmodule

// File: design/tdf_datapath.sv
module tdf_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [31:0]                          s_value,
    input  tdf_pkg::dp_cmd_t                     cmd,
    output tdf_pkg::dp_sts_t                     sts,
    output logic [tdf_pkg::FACTOR_WIDTH-1:0]     m_factor
);
    import tdf_pkg::*;

    logic [VALUE_WIDTH-1:0] rem_reg, rem_next;
    logic [VALUE_WIDTH-1:0] div_reg, div_next;
    logic [VALUE_WIDTH-1:0] dq_reg, dq_next;      // dividend, shifts into quotient
    logic [VALUE_WIDTH-1:0] part_reg, part_next;  // partial remainder
    logic [STEP_WIDTH-1:0]  step_reg, step_next;
    logic                   busy_reg, busy_next;
    logic [FACTOR_WIDTH-1:0] factor_reg, factor_next;

    logic [VALUE_WIDTH:0]   shifted;
    logic [VALUE_WIDTH-1:0] diff;
    logic                   fits;

    assign shifted = {part_reg, dq_reg[VALUE_WIDTH-1]};
    assign diff    = shifted[VALUE_WIDTH-1:0] - div_reg;
    assign fits    = shifted >= {1'b0, div_reg};

    always_comb begin
        rem_next    = rem_reg;
        div_next    = div_reg;
        dq_next     = dq_reg;
        part_next   = part_reg;
        step_next   = step_reg;
        busy_next   = busy_reg;
        factor_next = factor_reg;

        if (cmd.load) begin
            rem_next = VALUE_WIDTH'(s_value);
            div_next = VALUE_WIDTH'(2);
        end
        if (cmd.take_quot) begin
            rem_next = dq_reg;
        end
        if (cmd.inc_div) begin
            div_next = div_reg + VALUE_WIDTH'(1);
        end
        if (cmd.emit) begin
            factor_next = cmd.emit_rem ? FACTOR_WIDTH'(rem_reg) : FACTOR_WIDTH'(div_reg);
        end

        if (cmd.start) begin
            dq_next   = rem_reg;
            part_next = '0;
            step_next = STEP_WIDTH'(VALUE_WIDTH - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // restoring division, one quotient bit per cycle
            part_next = fits ? diff : shifted[VALUE_WIDTH-1:0];
            dq_next   = {dq_reg[VALUE_WIDTH-2:0], fits};
            step_next = step_reg - STEP_WIDTH'(1);
            if (step_reg == '0) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        rem_reg    <= rem_next;
        div_reg    <= div_next;
        dq_reg     <= dq_next;
        part_reg   <= part_next;
        step_reg   <= step_next;
        factor_reg <= factor_next;
    end

    assign sts.div_done    = busy_reg && (step_reg == '0);
    assign sts.rem_lt2     = rem_reg < VALUE_WIDTH'(2);
    assign sts.div_gt_quot = div_reg > dq_reg;
    assign sts.rem_zero    = part_reg == '0;
    assign sts.quot_one    = dq_reg == VALUE_WIDTH'(1);
    assign m_factor        = factor_reg;

endmodule

// File: design/tdf_controller.sv
module tdf_controller (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_last,
    output tdf_pkg::dp_cmd_t  cmd,
    input  tdf_pkg::dp_sts_t  sts
);
    import tdf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_START,
        ST_DIVIDE,
        ST_DECIDE
    } state_t;

    state_t               state_reg, state_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 m_last_reg, m_last_next;
    logic [CNT_WIDTH-1:0] count_reg, count_next;
    logic                 slot_free;
    logic                 at_limit;

    assign slot_free = !m_valid_reg || m_ready;
    assign at_limit  = count_reg == CNT_WIDTH'(MAX_RESULTS - 1);

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        m_last_next  = m_last_reg;
        count_next   = count_reg;
        cmd          = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    count_next = '0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = sts.rem_lt2 ? ST_IDLE : ST_START;
            end
            ST_START: begin
                cmd.start  = 1'b1;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (sts.div_done) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (sts.div_gt_quot) begin
                    // no divisor up to the square root: remainder is prime
                    if (slot_free) begin
                        cmd.emit     = 1'b1;
                        cmd.emit_rem = 1'b1;
                        m_valid_next = 1'b1;
                        m_last_next  = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end else if (sts.rem_zero) begin
                    if (slot_free) begin
                        cmd.emit      = 1'b1;
                        cmd.take_quot = 1'b1;
                        m_valid_next  = 1'b1;
                        m_last_next   = sts.quot_one || at_limit;
                        count_next    = count_reg + CNT_WIDTH'(1);
                        state_next    = (sts.quot_one || at_limit) ? ST_IDLE : ST_START;
                    end
                end else begin
                    cmd.inc_div = 1'b1;
                    state_next  = ST_START;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            m_last_reg  <= 1'b0;
            count_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            m_last_reg  <= m_last_next;
            count_reg   <= count_next;
        end
    end

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = m_valid_reg;
    assign m_last  = m_last_reg;

`ifndef SYNTHESIS
    a_emit_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> slot_free)
        else $error("result loaded while output register still occupied");

    a_idle_div_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !sts.div_done)
        else $error("divider running while controller idle");

    a_accept_check: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_CHECK))
        else $error("accepted transaction not checked next cycle");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_WIDTH'(MAX_RESULTS))
        else $error("result count past limit");
`endif

endmodule
